/* rtl/tcs_pkg.sv */
// Shared constants and types for the telnet command stripper.
// No dependencies; the parser, the output stage, the top level and the testbench refer to it by scoped name.
package tcs_pkg;

    // Telnet command codes
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SE   = 8'd240;

    // Result handed from the parser to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } push_t;

endpackage

/* rtl/tcs_if.sv */
// Valid/ready channel interfaces of the telnet command stripper.
// Depends on nothing; used by the parser, the output stage and the top level.
interface tcs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcs_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/telnet_command_stripper_core.sv */
// Telnet command stripper: top level with the bypass register.
// Depends on tcs_pkg, tcs_if, tcs_parser and tcs_out_stage.
//
// Usage:
//   rx  - received bytes, one per transfer (valid/ready).
//   tx  - data bytes kept after command removal, one per transfer.
//   cfg - one-bit bypass register; always ready. Write it only while idle.
// Each byte goes into an input register; the parser decodes it against the
// parse state and, if the byte is kept, loads the output register. A kept
// byte is driven on tx from the output register; dropped bytes
// (IAC, command, option and subnegotiation bytes) produce no transfer.
// Throughput is one byte per cycle while tx takes its bytes, set by the
// parse loop through the state register. When tx stalls with its
// register full, the next kept byte waits in the input register and rx
// ready falls; bytes that are dropped still pass through during the stall.
// Reset (rst_n low, asynchronous) empties both registers, returns the
// parser to normal data and clears bypass.
module telnet_command_stripper_core (
    input  logic       clk,
    input  logic       rst_n,
    tcs_byte_if.sink   rx,
    tcs_byte_if.source tx,
    tcs_cfg_if.sink    cfg
);

    logic           bypass_reg;
    logic           out_free;
    tcs_pkg::push_t push;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bypass_reg <= 1'b0;
        else if (cfg.valid && cfg.ready)
            bypass_reg <= cfg.data;
    end

    tcs_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .bypass   (bypass_reg),
        .out_free (out_free),
        .push     (push)
    );

    tcs_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .out_free (out_free),
        .tx       (tx)
    );

endmodule

/* rtl/tcs_parser.sv */
// Input register and telnet parse state machine.
// Depends on tcs_pkg and tcs_byte_if.
module tcs_parser (
    input  logic           clk,
    input  logic           rst_n,
    tcs_byte_if.sink       rx,
    input  logic           bypass,
    input  logic           out_free,
    output tcs_pkg::push_t push
);

    typedef enum logic [1:0] {
        ST_DATA   = 2'd0,
        ST_IAC    = 2'd1,
        ST_OPTION = 2'd2,
        ST_SUBNEG = 2'd3
    } parse_state_t;

    parse_state_t state_reg, state_next, state_calc;
    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         keep;
    logic [7:0]   keep_data;
    logic         advance;

    // Decode of the held byte against the current parse state
    always_comb
    begin
        keep       = 1'b0;
        keep_data  = in_byte_reg;
        state_calc = state_reg;
        if (bypass)
        begin
            keep = 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_DATA:
                begin
                    if (in_byte_reg == tcs_pkg::TN_IAC)
                        state_calc = ST_IAC;
                    else
                        keep = 1'b1;
                end
                ST_IAC:
                begin
                    if (in_byte_reg == tcs_pkg::TN_IAC)
                    begin
                        keep       = 1'b1;
                        state_calc = ST_DATA;
                    end
                    else if (in_byte_reg inside {tcs_pkg::TN_WILL, tcs_pkg::TN_WONT,
                                                 tcs_pkg::TN_DO, tcs_pkg::TN_DONT})
                        state_calc = ST_OPTION;
                    else if (in_byte_reg == tcs_pkg::TN_SB)
                        state_calc = ST_SUBNEG;
                    else
                        state_calc = ST_DATA;
                end
                ST_OPTION:
                    state_calc = ST_DATA;
                ST_SUBNEG:
                begin
                    if (in_byte_reg == tcs_pkg::TN_SE)
                        state_calc = ST_DATA;
                end
                default:
                    state_calc = ST_DATA;
            endcase
        end
    end

    // A dropped byte never waits on the output side
    assign advance  = in_valid_reg && (!keep || out_free);
    assign rx.ready = !in_valid_reg || advance;

    assign push.valid = advance && keep;
    assign push.data  = keep_data;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx.valid && rx.ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        state_next = advance ? state_calc : state_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= ST_DATA;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    // Held input byte
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.data;
    end

    // A result is only produced when the output register can take it
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> out_free)
        else $error("result pushed into a full output register");

    // Bypass leaves the parse state untouched
    a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && bypass) |=> $stable(state_reg))
        else $error("parse state changed during bypass");

    // Nothing escapes from a subnegotiation
    a_subneg_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !bypass && state_reg == ST_SUBNEG) |-> !push.valid)
        else $error("byte kept inside subnegotiation");

    // A held byte that cannot move stays put
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost or changed");

endmodule

/* rtl/tcs_out_stage.sv */
// Output register that drives the result channel.
// Depends on tcs_pkg and tcs_byte_if.
module tcs_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  tcs_pkg::push_t push,
    output logic           out_free,
    tcs_byte_if.source     tx
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;

    // Free when empty or draining this cycle
    assign out_free = !out_valid_reg || tx.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !tx.ready;
        if (push.valid)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            out_data_reg <= push.data;
    end

    assign tx.valid = out_valid_reg;
    assign tx.data  = out_data_reg;

endmodule

/* tb/telnet_command_stripper_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for telnet_command_stripper_core: drives bytes on rx,
// predicts the kept bytes on tx and checks them in order against that prediction.
// Depends on tcs_pkg, tcs_if and the RTL of the block.
module telnet_command_stripper_core_tb;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 4;    // extra wait once no kept byte is pending
    localparam int STALL_LIMIT  = 1000; // cycles with no transfer at all
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_SEQS   = 65;   // telnet sequences per phase

    typedef enum logic [1:0] {
        PS_DATA,
        PS_IAC,
        PS_OPTION,
        PS_SUBNEG
    } parse_state_t;

    // Predicts which bytes survive command removal and checks tx against them
    class tcs_scoreboard;
        parse_state_t state;
        logic         bypass;
        logic [7:0]   kept_q[$];
        int unsigned  errors;

        function new();
            state  = PS_DATA;
            bypass = 1'b0;
            errors = 0;
        endfunction

        function void set_bypass(logic value);
            bypass = value;
        endfunction

        // Accepted rx byte: advance the parser and queue the byte if kept
        function void note_rx(logic [7:0] b);
            if (bypass)
            begin
                kept_q.push_back(b);
                return;
            end
            case (state)
                PS_DATA:
                begin
                    if (b == tcs_pkg::TN_IAC)
                        state = PS_IAC;
                    else
                        kept_q.push_back(b);
                end
                PS_IAC:
                begin
                    if (b == tcs_pkg::TN_IAC)
                    begin
                        state = PS_DATA;
                        kept_q.push_back(tcs_pkg::TN_IAC);
                    end
                    else if (b == tcs_pkg::TN_WILL || b == tcs_pkg::TN_WONT ||
                             b == tcs_pkg::TN_DO || b == tcs_pkg::TN_DONT)
                        state = PS_OPTION;
                    else if (b == tcs_pkg::TN_SB)
                        state = PS_SUBNEG;
                    else
                        state = PS_DATA;
                end
                PS_OPTION:
                    state = PS_DATA;
                default:
                begin
                    if (b == tcs_pkg::TN_SE)
                        state = PS_DATA;
                end
            endcase
        endfunction

        // Accepted tx byte: compare with the oldest kept byte
        function void check_tx(logic [7:0] b);
            logic [7:0] want;
            if (kept_q.size() == 0)
            begin
                $display("%0t ERROR: unexpected tx byte, expected none, actual 0x%02h",
                         $time, b);
                errors++;
                return;
            end
            want = kept_q.pop_front();
            if (b !== want)
            begin
                $display("%0t ERROR: out_byte expected 0x%02h, actual 0x%02h",
                         $time, want, b);
                errors++;
            end
        endfunction

        function int pending();
            return kept_q.size();
        endfunction

        function void flag_leftovers();
            foreach (kept_q[i])
            begin
                $display("%0t ERROR: out_byte expected 0x%02h, actual none",
                         $time, kept_q[i]);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic idle_on;
    int   stall_count = 0;

    tcs_byte_if rx_if();
    tcs_byte_if tx_if();
    tcs_cfg_if  cfg_if();

    tcs_scoreboard sb = new();

    telnet_command_stripper_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if),
        .cfg   (cfg_if)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Transfer monitor: feeds the scoreboard, rx before tx
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                sb.set_bypass(cfg_if.data);
            if (rx_if.valid && rx_if.ready)
                sb.note_rx(rx_if.data);
            if (tx_if.valid && tx_if.ready)
                sb.check_tx(tx_if.data);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver backpressure in random bursts
    initial
    begin
        tx_if.ready <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                tx_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                tx_if.ready <= 1'b1;
            end
        end
    end

    // One rx transfer, with an occasional gap in front of it
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data  <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
    endtask

    // Sender pauses until every kept byte is out and the pipe is empty
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bypass(input logic value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly well-formed telnet traffic with random content, some noise
    task automatic send_random_sequence();
        int         kind;
        int         len;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 35)
            send_byte(8'($urandom_range(0, 254)));
        else if (kind < 45)
        begin
            send_byte(tcs_pkg::TN_IAC);
            send_byte(tcs_pkg::TN_IAC);
        end
        else if (kind < 65)
        begin
            send_byte(tcs_pkg::TN_IAC);
            b = tcs_pkg::TN_WILL + 8'($urandom_range(0, 3));
            send_byte(b);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 80)
        begin
            send_byte(tcs_pkg::TN_IAC);
            send_byte(tcs_pkg::TN_SB);
            len = $urandom_range(0, 6);
            repeat (len)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == tcs_pkg::TN_SE)
                    b = tcs_pkg::TN_IAC;
                send_byte(b);
            end
            send_byte(tcs_pkg::TN_SE);
        end
        else if (kind < 88)
        begin
            // IAC followed by a byte below SB, which the parser drops as a lone command
            send_byte(tcs_pkg::TN_IAC);
            send_byte(8'($urandom_range(0, 249)));
        end
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Stimulus
    initial
    begin
        logic [7:0] directed_q[$];
        logic       bypass_val;

        rst_n        <= 1'b0;
        idle_on      <= 1'b1;
        rx_if.valid  <= 1'b0;
        rx_if.data   <= 8'h00;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: NUL, IAC IAC, each negotiation command, subnegotiation
        // with an inner IAC, empty subnegotiation, IAC with an unknown byte
        write_bypass(1'b0);
        directed_q = '{8'h00, tcs_pkg::TN_IAC, tcs_pkg::TN_IAC, 8'hFE,
                       tcs_pkg::TN_IAC, tcs_pkg::TN_DO, 8'h01,
                       tcs_pkg::TN_IAC, tcs_pkg::TN_DONT, 8'hFF,
                       tcs_pkg::TN_IAC, tcs_pkg::TN_WILL, 8'h00,
                       tcs_pkg::TN_IAC, tcs_pkg::TN_WONT, 8'h18,
                       tcs_pkg::TN_IAC, tcs_pkg::TN_SB, tcs_pkg::TN_IAC,
                       tcs_pkg::TN_SE,
                       tcs_pkg::TN_IAC, tcs_pkg::TN_SB, tcs_pkg::TN_SE,
                       tcs_pkg::TN_IAC, 8'hF1, 8'h7F};
        foreach (directed_q[i])
            send_byte(directed_q[i]);
        // Bypass while inside subnegotiation: the parse state is held
        send_byte(tcs_pkg::TN_IAC);
        send_byte(tcs_pkg::TN_SB);
        wait_idle();
        write_bypass(1'b1);
        send_byte(tcs_pkg::TN_IAC);
        send_byte(tcs_pkg::TN_SE);
        send_byte(8'h00);
        wait_idle();
        write_bypass(1'b0);
        send_byte(8'h41);
        send_byte(tcs_pkg::TN_SE);
        send_byte(8'h42);
        wait_idle();

        // Random phases with changing bypass; the last one runs without gaps
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 4)
                bypass_val = p[0];
            else if (p == 4)
                bypass_val = 1'($urandom_range(0, 1));
            else
                bypass_val = 1'b0;
            if (p == NUM_PHASES - 1)
                idle_on <= 1'b0;
            write_bypass(bypass_val);
            for (int n = 0; n < PHASE_SEQS; n += 1)
                send_random_sequence();
            wait_idle();
        end

        sb.flag_leftovers();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tcs_pkg.sv
rtl/tcs_if.sv
rtl/tcs_parser.sv
rtl/tcs_out_stage.sv
rtl/telnet_command_stripper_core.sv
tb/telnet_command_stripper_core_tb.sv
